// ===== hdl/lplf_pkg.sv =====
// Shared constants, types and prefix tables of the log line prefix filter.
package lplf_pkg;

    localparam int HEAD_DEPTH   = 48;
    localparam int RETURN_LIMIT = 15;
    localparam int BUFFER_BYTES = 4194304;

    localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
    localparam int HEAD_CW    = $clog2(HEAD_DEPTH + 1);
    localparam int RET_W      = $clog2(RETURN_LIMIT + 1);
    localparam int CNT_W      = 23;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int NPREFIX    = 5;
    localparam int PFX_MAX    = 13;
    localparam int PFX_PW     = 4;

    localparam logic [CNT_W-1:0] EMIT_LIMIT = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] EMIT_LAST  = CNT_W'(BUFFER_BYTES - 1);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [0:PFX_MAX-1][7:0] t_pfx_text;

    localparam t_pfx_text PFX_TEXT [NPREFIX] = '{
        {"EE [Info]", 32'h0},
        {"Sys [Info]", 24'h0},
        "Script [Info]",
        {"AI [Info]", 32'h0},
        {"Net [Info]", 24'h0}
    };

    localparam logic [PFX_PW-1:0] PFX_LEN [NPREFIX] = '{
        4'd9, 4'd10, 4'd13, 4'd9, 4'd10
    };

    typedef enum logic [2:0] {
        PH_START,
        PH_DIGITS,
        PH_FRAC,
        PH_SPACE,
        PH_PREFIX,
        PH_PASS,
        PH_DROP
    } t_phase;

    typedef enum logic [2:0] {
        B_IDLE,
        B_REL_RD,
        B_REL_EMIT,
        B_RET,
        B_BYTE,
        B_SUM
    } t_back_st;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_summary;
        logic [CNT_W-1:0] byte_count;
        logic             overflow_seen;
        logic             last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [HEAD_CW-1:0] head_n;
        logic [RET_W-1:0]   ret_n;
        logic               has_byte;
        logic [7:0]         byte_val;
        logic               summary;
        logic               ovf;
    } t_cmd;

    typedef struct packed {
        logic               en;
        logic [HEAD_AW-1:0] addr;
        logic [7:0]         data;
    } t_ram_wr;

endpackage

// ===== hdl/lplf_head_ram.sv =====
// Line head store: one write port and one registered read port.
module lplf_head_ram (
    input  logic                         i_clk,
    input  lplf_pkg::t_ram_wr            i_wr,
    input  logic [lplf_pkg::HEAD_AW-1:0] i_rd_addr,
    output logic [7:0]                   o_rd_data
);

    logic [7:0] r_mem [lplf_pkg::HEAD_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lplf_cmd_fifo.sv =====
// Short command queue between the classifying front end and the output back end.
module lplf_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lplf_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output lplf_pkg::t_cmd o_data,
    output logic           o_empty
);

    lplf_pkg::t_cmd r_mem [lplf_pkg::CMDQ_DEPTH];
    logic [lplf_pkg::CMDQ_AW-1:0] r_wr_ptr;
    logic [lplf_pkg::CMDQ_AW-1:0] r_rd_ptr;
    logic [lplf_pkg::CMDQ_AW:0]   r_count;
    logic [lplf_pkg::CMDQ_AW-1:0] n_wr_ptr;
    logic [lplf_pkg::CMDQ_AW-1:0] n_rd_ptr;

    always_comb begin
        if (r_wr_ptr == lplf_pkg::CMDQ_AW'(lplf_pkg::CMDQ_DEPTH - 1)) begin
            n_wr_ptr = '0;
        end else begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (r_rd_ptr == lplf_pkg::CMDQ_AW'(lplf_pkg::CMDQ_DEPTH - 1)) begin
            n_rd_ptr = '0;
        end else begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10: r_count <= r_count + 1'b1;
                2'b01: r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (lplf_pkg::CMDQ_AW + 1)'(lplf_pkg::CMDQ_DEPTH));

endmodule

// ===== hdl/lplf_front.sv =====
// Front end: accepts input bytes, tracks the line pattern and issues output commands.
module lplf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lplf_pkg::t_in_item  i_in_item,
    output logic                o_full,
    output lplf_pkg::t_ram_wr   o_ram_wr,
    output logic                o_cmd_push,
    output lplf_pkg::t_cmd      o_cmd,
    input  logic                i_cmd_full,
    input  logic                i_rel_done
);

    lplf_pkg::t_phase                r_phase;
    logic [lplf_pkg::HEAD_CW-1:0]    r_head_cnt;
    logic [lplf_pkg::NPREFIX-1:0]    r_alive;
    logic [lplf_pkg::PFX_PW-1:0]     r_pos;
    logic [lplf_pkg::RET_W-1:0]      r_pend;
    logic                            r_ovf;
    logic                            r_rel_busy;

    lplf_pkg::t_phase                n_phase;
    logic [lplf_pkg::HEAD_CW-1:0]    n_head_cnt;
    logic [lplf_pkg::NPREFIX-1:0]    n_alive;
    logic [lplf_pkg::PFX_PW-1:0]     n_pos;
    logic [lplf_pkg::RET_W-1:0]      n_pend;
    logic                            n_ovf;

    logic [7:0]                      c;
    logic                            eob;
    logic                            is_digit;
    logic                            is_blank;
    logic                            accept;
    logic                            hold_req;
    logic                            hold_full;
    logic                            pfx_req;
    logic                            pfx_done;
    logic                            line_clr;
    logic                            rel_set;
    logic                            wr_en;
    lplf_pkg::t_phase                hold_phase;
    logic [lplf_pkg::NPREFIX-1:0]    alive_nx;
    lplf_pkg::t_cmd                  cmd;

    assign c        = i_in_item.data_byte;
    assign eob      = i_in_item.end_of_buffer;
    assign is_digit = (c >= lplf_pkg::CH_ZERO) && (c <= lplf_pkg::CH_NINE);
    assign is_blank = (c == lplf_pkg::CH_SPACE) || (c == lplf_pkg::CH_TAB);

    always_comb begin
        alive_nx = '0;
        pfx_done = 1'b0;
        for (int k = 0; k < lplf_pkg::NPREFIX; k++) begin
            if (r_alive[k] && (r_pos < lplf_pkg::PFX_LEN[k])
                    && (lplf_pkg::PFX_TEXT[k][r_pos] == c)) begin
                alive_nx[k] = 1'b1;
                if (r_pos + 1'b1 == lplf_pkg::PFX_LEN[k]) begin
                    pfx_done = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_head_cnt = r_head_cnt;
        n_alive    = r_alive;
        n_pos      = r_pos;
        n_pend     = r_pend;
        n_ovf      = r_ovf;
        hold_req   = 1'b0;
        hold_phase = r_phase;
        pfx_req    = 1'b0;
        line_clr   = 1'b0;
        rel_set    = 1'b0;
        wr_en      = 1'b0;
        hold_full  = (r_head_cnt >= lplf_pkg::HEAD_CW'(lplf_pkg::HEAD_DEPTH));
        cmd        = '0;
        cmd.byte_val = c;

        if ((c == lplf_pkg::CH_NL) && (r_phase != lplf_pkg::PH_PASS)) begin
            line_clr = 1'b1;
        end else begin
            unique case (r_phase)
                lplf_pkg::PH_START: begin
                    if (is_digit) begin
                        hold_req   = 1'b1;
                        hold_phase = lplf_pkg::PH_DIGITS;
                    end else begin
                        n_phase = lplf_pkg::PH_DROP;
                    end
                end
                lplf_pkg::PH_DIGITS, lplf_pkg::PH_FRAC: begin
                    if (is_digit) begin
                        hold_req = 1'b1;
                    end else if ((c == lplf_pkg::CH_DOT) && (r_phase == lplf_pkg::PH_DIGITS)) begin
                        hold_req   = 1'b1;
                        hold_phase = lplf_pkg::PH_FRAC;
                    end else if (is_blank) begin
                        hold_req   = 1'b1;
                        hold_phase = lplf_pkg::PH_SPACE;
                    end else begin
                        pfx_req = 1'b1;
                    end
                end
                lplf_pkg::PH_SPACE: begin
                    if (is_blank) begin
                        hold_req = 1'b1;
                    end else begin
                        pfx_req = 1'b1;
                    end
                end
                lplf_pkg::PH_PREFIX: begin
                    pfx_req = 1'b1;
                end
                lplf_pkg::PH_PASS: begin
                    if (c == lplf_pkg::CH_NL) begin
                        n_pend       = '0;
                        cmd.has_byte = 1'b1;
                        line_clr     = 1'b1;
                    end else if (c == lplf_pkg::CH_CR) begin
                        if (r_pend >= lplf_pkg::RET_W'(lplf_pkg::RETURN_LIMIT)) begin
                            cmd.ret_n    = r_pend;
                            cmd.has_byte = 1'b1;
                            n_pend       = '0;
                            n_ovf        = 1'b1;
                        end else begin
                            n_pend = r_pend + 1'b1;
                        end
                    end else begin
                        cmd.ret_n    = r_pend;
                        cmd.has_byte = 1'b1;
                        n_pend       = '0;
                    end
                end
                lplf_pkg::PH_DROP: begin
                    n_phase = lplf_pkg::PH_DROP;
                end
                default: begin
                    n_phase = lplf_pkg::PH_DROP;
                end
            endcase
        end

        if (pfx_req) begin
            n_alive = alive_nx;
            n_pos   = r_pos + 1'b1;
            if (alive_nx == '0) begin
                n_phase    = lplf_pkg::PH_DROP;
                n_head_cnt = '0;
            end else begin
                hold_req   = 1'b1;
                hold_phase = lplf_pkg::PH_PREFIX;
            end
        end

        if (hold_req) begin
            if (hold_full) begin
                n_ovf      = 1'b1;
                n_phase    = lplf_pkg::PH_DROP;
                n_head_cnt = '0;
            end else begin
                wr_en      = 1'b1;
                n_head_cnt = r_head_cnt + 1'b1;
                n_phase    = hold_phase;
                if (pfx_req && pfx_done) begin
                    cmd.head_n = r_head_cnt + 1'b1;
                    n_phase    = lplf_pkg::PH_PASS;
                    n_head_cnt = '0;
                    rel_set    = 1'b1;
                end
            end
        end

        if (eob) begin
            if ((n_phase == lplf_pkg::PH_PASS) && !cmd.has_byte) begin
                cmd.ret_n = n_pend;
            end
            cmd.summary = 1'b1;
            cmd.ovf     = n_ovf;
            n_ovf       = 1'b0;
        end

        if (line_clr || eob) begin
            n_phase    = lplf_pkg::PH_START;
            n_head_cnt = '0;
            n_alive    = '1;
            n_pos      = '0;
            n_pend     = '0;
        end
    end

    // A new line head may not be written while the back end still reads the last one.
    assign o_full = i_cmd_full || (r_rel_busy && (r_phase != lplf_pkg::PH_PASS)
                                   && (r_phase != lplf_pkg::PH_DROP));
    assign accept = i_push && !o_full;

    assign o_ram_wr.en   = accept && wr_en;
    assign o_ram_wr.addr = r_head_cnt[lplf_pkg::HEAD_AW-1:0];
    assign o_ram_wr.data = c;

    assign o_cmd      = cmd;
    assign o_cmd_push = accept && ((cmd.head_n != '0) || (cmd.ret_n != '0)
                                   || cmd.has_byte || cmd.summary);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lplf_pkg::PH_START;
            r_head_cnt <= '0;
            r_alive    <= '1;
            r_pos      <= '0;
            r_pend     <= '0;
            r_ovf      <= 1'b0;
            r_rel_busy <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_head_cnt <= n_head_cnt;
                r_alive    <= n_alive;
                r_pos      <= n_pos;
                r_pend     <= n_pend;
                r_ovf      <= n_ovf;
            end
            if (accept && rel_set) begin
                r_rel_busy <= 1'b1;
            end else if (i_rel_done) begin
                r_rel_busy <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_no_write_during_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_wr.en |-> !r_rel_busy)
        else $error("head store written while a release is outstanding");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_cmd_full)
        else $error("command pushed into a full queue");
`endif

endmodule

// ===== hdl/lplf_back.sv =====
// Back end: carries out commands and presents result beats through an output register.
module lplf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lplf_pkg::t_cmd               i_cmd,
    input  logic                         i_cmd_empty,
    output logic                         o_cmd_pop,
    output logic                         o_rel_done,
    output logic [lplf_pkg::HEAD_AW-1:0] o_rd_addr,
    input  logic [7:0]                   i_rd_data,
    input  logic                         i_pop,
    output logic                         o_empty,
    output lplf_pkg::t_out_item          o_out_item
);

    lplf_pkg::t_back_st              r_state;
    lplf_pkg::t_cmd                  r_cmd;
    logic [lplf_pkg::HEAD_AW-1:0]    r_rel_idx;
    logic [lplf_pkg::RET_W-1:0]      r_ret_idx;
    logic [lplf_pkg::CNT_W-1:0]      r_emit;
    logic                            r_out_valid;
    lplf_pkg::t_out_item             r_out;

    lplf_pkg::t_back_st              n_state;
    lplf_pkg::t_cmd                  n_cmd;
    logic [lplf_pkg::HEAD_AW-1:0]    n_rel_idx;
    logic [lplf_pkg::RET_W-1:0]      n_ret_idx;
    logic [lplf_pkg::CNT_W-1:0]      n_emit;
    logic                            n_out_valid;
    lplf_pkg::t_out_item             n_out;

    logic                            slot;
    logic                            lim_hit;
    logic                            last_cap;
    logic                            rel_end;
    logic                            ret_end;
    logic                            data_go;
    logic                            data_last;
    logic [7:0]                      data_val;
    lplf_pkg::t_back_st              skip_st;

    // Picks the next part of a command after the part that state s stands for.
    function automatic lplf_pkg::t_back_st step_from(input lplf_pkg::t_cmd c,
                                                     input lplf_pkg::t_back_st s);
        lplf_pkg::t_back_st r;
        r = lplf_pkg::B_IDLE;
        if (c.summary) begin
            r = lplf_pkg::B_SUM;
        end
        if (c.has_byte && (s != lplf_pkg::B_BYTE)) begin
            r = lplf_pkg::B_BYTE;
        end
        if ((c.ret_n != '0) && ((s == lplf_pkg::B_IDLE) || (s == lplf_pkg::B_REL_EMIT))) begin
            r = lplf_pkg::B_RET;
        end
        if ((c.head_n != '0) && (s == lplf_pkg::B_IDLE)) begin
            r = lplf_pkg::B_REL_RD;
        end
        return r;
    endfunction

    assign slot     = !r_out_valid || i_pop;
    assign lim_hit  = (r_emit == lplf_pkg::EMIT_LIMIT);
    assign last_cap = (r_emit == lplf_pkg::EMIT_LAST);
    assign rel_end  = (lplf_pkg::HEAD_CW'(r_rel_idx) + 1'b1 == r_cmd.head_n);
    assign ret_end  = (r_ret_idx + 1'b1 == r_cmd.ret_n);
    assign skip_st  = r_cmd.summary ? lplf_pkg::B_SUM : lplf_pkg::B_IDLE;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_rel_idx   = r_rel_idx;
        n_ret_idx   = r_ret_idx;
        n_emit      = r_emit;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        o_rel_done  = 1'b0;
        data_go     = 1'b0;
        data_last   = 1'b0;
        data_val    = r_cmd.byte_val;

        unique case (r_state)
            lplf_pkg::B_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_rel_idx = '0;
                    n_ret_idx = '0;
                    n_state   = step_from(i_cmd, lplf_pkg::B_IDLE);
                end
            end
            lplf_pkg::B_REL_RD: begin
                n_state = lplf_pkg::B_REL_EMIT;
            end
            lplf_pkg::B_REL_EMIT: begin
                if (lim_hit) begin
                    n_state    = skip_st;
                    o_rel_done = 1'b1;
                end else if (slot) begin
                    data_go   = 1'b1;
                    data_val  = i_rd_data;
                    data_last = rel_end && (r_cmd.ret_n == '0) && !r_cmd.has_byte;
                    if (rel_end) begin
                        n_state    = step_from(r_cmd, lplf_pkg::B_REL_EMIT);
                        o_rel_done = 1'b1;
                    end else begin
                        n_rel_idx = r_rel_idx + 1'b1;
                        n_state   = lplf_pkg::B_REL_RD;
                    end
                end
            end
            lplf_pkg::B_RET: begin
                if (lim_hit) begin
                    n_state = skip_st;
                end else if (slot) begin
                    data_go   = 1'b1;
                    data_val  = lplf_pkg::CH_CR;
                    data_last = ret_end && !r_cmd.has_byte;
                    if (ret_end) begin
                        n_state = step_from(r_cmd, lplf_pkg::B_RET);
                    end else begin
                        n_ret_idx = r_ret_idx + 1'b1;
                    end
                end
            end
            lplf_pkg::B_BYTE: begin
                if (lim_hit) begin
                    n_state = skip_st;
                end else if (slot) begin
                    data_go   = 1'b1;
                    data_last = 1'b1;
                    n_state   = step_from(r_cmd, lplf_pkg::B_BYTE);
                end
            end
            lplf_pkg::B_SUM: begin
                if (slot) begin
                    n_out_valid         = 1'b1;
                    n_out.out_byte      = '0;
                    n_out.is_summary    = 1'b1;
                    n_out.byte_count    = r_emit;
                    n_out.overflow_seen = r_cmd.ovf;
                    n_out.last_of_run   = 1'b1;
                    n_emit              = '0;
                    n_state             = lplf_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = lplf_pkg::B_IDLE;
            end
        endcase

        if (data_go) begin
            n_out_valid         = 1'b1;
            n_out.out_byte      = data_val;
            n_out.is_summary    = 1'b0;
            n_out.byte_count    = '0;
            n_out.overflow_seen = 1'b0;
            n_out.last_of_run   = !r_cmd.summary && (data_last || last_cap);
            n_emit              = r_emit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lplf_pkg::B_IDLE;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
            r_rel_idx   <= '0;
            r_ret_idx   <= '0;
        end else begin
            r_state     <= n_state;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
            r_rel_idx   <= n_rel_idx;
            r_ret_idx   <= n_ret_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    assign o_rd_addr  = r_rel_idx;
    assign o_empty    = !r_out_valid;
    assign o_out_item = r_out;

`ifndef SYNTH
    a_read_before_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lplf_pkg::B_REL_EMIT) |->
            ($past(r_state) == lplf_pkg::B_REL_RD) || ($past(r_state) == lplf_pkg::B_REL_EMIT))
        else $error("head byte emitted without a completed store read");

    a_done_only_in_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rel_done |-> (r_state == lplf_pkg::B_REL_EMIT))
        else $error("release done reported outside a release");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= lplf_pkg::EMIT_LIMIT)
        else $error("emitted byte count beyond the buffer limit");
`endif

endmodule

// ===== hdl/log_line_prefix_filter.sv =====
// Top level of the log line prefix filter: front end, command queue, head store, back end.
// Bytes of a buffer go in through push/full, one beat per byte, and the front end takes a
// byte in every cycle unless the command queue is full or a new line head would overwrite
// a head that is still being released. Each byte that causes output becomes one command;
// the back end takes a command in B_IDLE and then emits its result beats, each when the
// output register has room, and a released head byte passes B_REL_RD before B_REL_EMIT
// because every head store read is registered before the byte leaves. The held line head is
// at most HEAD_DEPTH bytes; the store has no reset and needs no clearing pass. Results leave
// through empty/pop from an output register, and the summary beat ends every buffer.
module log_line_prefix_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  lplf_pkg::t_in_item  i_in_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output lplf_pkg::t_out_item o_out_item
);

    lplf_pkg::t_ram_wr            ram_wr;
    logic [lplf_pkg::HEAD_AW-1:0] rd_addr;
    logic [7:0]                   rd_data;
    logic                         cmd_push;
    lplf_pkg::t_cmd               cmd_in;
    logic                         cmd_full;
    logic                         cmd_pop;
    lplf_pkg::t_cmd               cmd_out;
    logic                         cmd_empty;
    logic                         rel_done;

    lplf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_item  (i_in_item),
        .o_full     (full),
        .o_ram_wr   (ram_wr),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full),
        .i_rel_done (rel_done)
    );

    lplf_head_ram u_head_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lplf_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    lplf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_rel_done  (rel_done),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule
